[rtl/itp_pkg.sv]
// Shared types, constants and character helpers for the integer text parser.
`timescale 1ns / 1ps

package itp_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CHARS_BITS     = 16;

    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] RADIX_AUTO  = 6'd0;
    localparam logic [5:0] RADIX_ONE   = 6'd1;
    localparam logic [5:0] RADIX_OCT   = 6'd8;
    localparam logic [5:0] RADIX_DEC   = 6'd10;
    localparam logic [5:0] RADIX_HEX   = 6'd16;
    localparam logic [5:0] RADIX_MAX   = 6'd36;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] LETTER_BASE = 8'd10;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SPACE  = 3'd1,
        PH_PREFIX = 3'd2,
        PH_ZERO   = 3'd3,
        PH_DIGITS = 3'd4
    } t_phase;

    // Per-parse control state handed between the step logic and its registers
    typedef struct packed {
        t_phase     phase;
        logic       minus;
        logic [5:0] radix;
    } t_ctl;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_digit;

    function automatic t_digit char_digit(input logic [7:0] c);
        t_digit d;
        d.ok  = 1'b1;
        d.val = 6'd0;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            d.val = 6'(c - CH_ZERO);
        end else if (c inside {[CH_LA:CH_LZ]}) begin
            d.val = 6'(c - CH_LA + LETTER_BASE);
        end else if (c inside {[CH_UA:CH_UZ]}) begin
            d.val = 6'(c - CH_UA + LETTER_BASE);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

endpackage

[rtl/itp_step.sv]
// Per-character parse step: next parse state and the result of a finished parse.
`timescale 1ns / 1ps

module itp_step #(
    parameter int VALUE_BITS = itp_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = itp_pkg::COUNT_BITS_DEF
) (
    input  itp_pkg::t_ctl                  i_ctl,
    input  logic [VALUE_BITS-1:0]          i_acc,
    input  logic [COUNT_BITS-1:0]          i_cnt,
    input  logic [5:0]                     i_radix,
    input  logic [7:0]                     i_ch,
    output itp_pkg::t_ctl                  o_ctl,
    output logic [VALUE_BITS-1:0]          o_acc,
    output logic [COUNT_BITS-1:0]          o_cnt,
    output logic                           o_emit,
    output logic                           o_bad,
    output logic [VALUE_BITS-1:0]          o_value,
    output logic [itp_pkg::CHARS_BITS-1:0] o_chars
);

    localparam int CW = (COUNT_BITS > itp_pkg::CHARS_BITS) ? COUNT_BITS : itp_pkg::CHARS_BITS;
    localparam logic [CW-1:0] CHARS_SAT = CW'({itp_pkg::CHARS_BITS{1'b1}});

    itp_pkg::t_digit dg;
    itp_pkg::t_phase ph;
    logic [5:0]      rad;
    logic            done;
    logic            incr;
    logic            emit;
    logic            bad;
    logic [CW-1:0]   cnt_ext;

    assign dg = itp_pkg::char_digit(i_ch);

    // Next state: the phases fall through within one character, as far as needed
    always_comb begin
        o_ctl = i_ctl;
        o_acc = i_acc;
        o_cnt = i_cnt;
        emit  = 1'b0;
        bad   = 1'b0;
        done  = 1'b0;
        incr  = 1'b0;
        rad   = i_ctl.radix;
        ph    = i_ctl.phase;

        if (ph == itp_pkg::PH_START) begin
            rad = i_radix;
            if (rad == itp_pkg::RADIX_ONE || rad > itp_pkg::RADIX_MAX) begin
                emit = 1'b1;
                bad  = 1'b1;
                done = 1'b1;
            end else begin
                ph = itp_pkg::PH_SPACE;
            end
        end

        if (!done && ph == itp_pkg::PH_SPACE) begin
            if (itp_pkg::is_space(i_ch)) begin
                incr        = 1'b1;
                done        = 1'b1;
                o_ctl.phase = itp_pkg::PH_SPACE;
                o_ctl.radix = rad;
            end else begin
                ph = itp_pkg::PH_PREFIX;
                if (i_ch == itp_pkg::CH_PLUS || i_ch == itp_pkg::CH_MINUS) begin
                    incr        = 1'b1;
                    done        = 1'b1;
                    o_ctl.minus = (i_ch == itp_pkg::CH_MINUS);
                    o_ctl.phase = itp_pkg::PH_PREFIX;
                    o_ctl.radix = rad;
                end
            end
        end

        if (!done && ph == itp_pkg::PH_PREFIX) begin
            if (rad == itp_pkg::RADIX_AUTO || rad == itp_pkg::RADIX_HEX) begin
                if (i_ch == itp_pkg::CH_ZERO) begin
                    if (rad == itp_pkg::RADIX_AUTO) begin
                        rad = itp_pkg::RADIX_OCT;
                    end
                    incr        = 1'b1;
                    done        = 1'b1;
                    o_ctl.phase = itp_pkg::PH_ZERO;
                    o_ctl.radix = rad;
                end else if (rad == itp_pkg::RADIX_AUTO) begin
                    rad = itp_pkg::RADIX_DEC;
                end
            end
            ph = itp_pkg::PH_DIGITS;
        end else if (!done && ph == itp_pkg::PH_ZERO) begin
            ph = itp_pkg::PH_DIGITS;
            if (i_ch == itp_pkg::CH_LX || i_ch == itp_pkg::CH_UX) begin
                rad         = itp_pkg::RADIX_HEX;
                incr        = 1'b1;
                done        = 1'b1;
                o_ctl.phase = itp_pkg::PH_DIGITS;
                o_ctl.radix = rad;
            end
        end

        if (!done) begin
            if (dg.ok && dg.val < rad) begin
                o_acc       = i_acc * VALUE_BITS'(rad) + VALUE_BITS'(dg.val);
                incr        = 1'b1;
                o_ctl.phase = ph;
                o_ctl.radix = rad;
            end else begin
                emit = 1'b1;
            end
        end

        if (emit) begin
            o_ctl.phase = itp_pkg::PH_START;
            o_ctl.minus = 1'b0;
            o_ctl.radix = itp_pkg::RADIX_AUTO;
            o_acc       = '0;
            o_cnt       = '0;
        end else if (incr && i_cnt != {COUNT_BITS{1'b1}}) begin
            o_cnt = i_cnt + 1'b1;
        end
    end

    assign cnt_ext = CW'(i_cnt);

    // Result fields of a parse that ends on this character
    always_comb begin
        o_emit = emit;
        o_bad  = bad;
        if (bad) begin
            o_value = '0;
            o_chars = '0;
        end else begin
            o_value = i_ctl.minus ? (~i_acc + 1'b1) : i_acc;
            o_chars = (cnt_ext > CHARS_SAT) ? {itp_pkg::CHARS_BITS{1'b1}}
                                            : cnt_ext[itp_pkg::CHARS_BITS-1:0];
        end
    end

endmodule

[rtl/integer_text_parser.sv]
// Top level of the integer text parser: input register, parse state, result register.
// The step reads the input register; a finished parse is registered in the result register.
// Throughput: one character per cycle while no result is blocked; the parse step is one
//   multiply-add by a 6-bit radix.
// A result waiting on i_m_tready holds the step; with the input reg full, o_s_tready drops.
// Reset (i_rst_n low, synchronous): radix 10, parser at start of parse, both stages empty.
`timescale 1ns / 1ps

module integer_text_parser #(
    parameter int VALUE_BITS = itp_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = itp_pkg::COUNT_BITS_DEF,
    localparam int OUT_W = ((VALUE_BITS + itp_pkg::CHARS_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [5:0]       i_cfg_wdata,  // radix
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,    // ch
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,    // value, chars_used, zero pad
    output logic [0:0]       o_m_tuser     // bad_radix
);

    logic                           r_in_vld;
    logic [7:0]                     r_in_ch;
    logic [5:0]                     r_radix;
    itp_pkg::t_ctl                  r_ctl;
    logic [VALUE_BITS-1:0]          r_acc;
    logic [COUNT_BITS-1:0]          r_cnt;
    logic                           r_out_vld;
    logic [VALUE_BITS-1:0]          r_out_value;
    logic [itp_pkg::CHARS_BITS-1:0] r_out_chars;
    logic                           r_out_bad;

    itp_pkg::t_ctl                  n_ctl;
    logic [VALUE_BITS-1:0]          n_acc;
    logic [COUNT_BITS-1:0]          n_cnt;
    logic                           step_emit;
    logic                           step_bad;
    logic [VALUE_BITS-1:0]          step_value;
    logic [itp_pkg::CHARS_BITS-1:0] step_chars;

    logic out_free;
    logic consume;
    logic in_beat;

    assign out_free   = !r_out_vld || i_m_tready;
    assign consume    = r_in_vld && out_free;
    assign o_s_tready = !r_in_vld || out_free;
    assign in_beat    = i_s_tvalid && o_s_tready;

    itp_step #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_ctl   (r_ctl),
        .i_acc   (r_acc),
        .i_cnt   (r_cnt),
        .i_radix (r_radix),
        .i_ch    (r_in_ch),
        .o_ctl   (n_ctl),
        .o_acc   (n_acc),
        .o_cnt   (n_cnt),
        .o_emit  (step_emit),
        .o_bad   (step_bad),
        .o_value (step_value),
        .o_chars (step_chars)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= itp_pkg::RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_beat) begin
            r_in_vld <= 1'b1;
        end else if (consume) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_ch <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.phase <= itp_pkg::PH_START;
            r_ctl.minus <= 1'b0;
            r_ctl.radix <= itp_pkg::RADIX_AUTO;
            r_acc       <= '0;
            r_cnt       <= '0;
        end else if (consume) begin
            r_ctl <= n_ctl;
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (consume && step_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && step_emit) begin
            r_out_value <= step_value;
            r_out_chars <= step_chars;
            r_out_bad   <= step_bad;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_W'({r_out_chars, r_out_value});
    assign o_m_tuser  = r_out_bad;

endmodule

[rtl/itp_checker.sv]
// Port-level checks for the integer text parser, bound to its top level.
`timescale 1ns / 1ps

module itp_checker #(
    parameter int DATA_BITS = 80
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [DATA_BITS-1:0] o_m_tdata,
    input logic [0:0]           o_m_tuser
);

    // The result stage comes up empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_m_tvalid)
        else $error("result beat valid right after reset");

    // Input side only stalls when the result register is full and blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without a blocked result");

    // A bad radix result carries zero value and zero count
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("bad radix beat with nonzero payload");

    // A blocked result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("result beat changed while stalled");

endmodule

bind integer_text_parser itp_checker #(
    .DATA_BITS (OUT_W)
) u_itp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
